@@ rtl/caf_pkg.sv @@
// Package: operation codes, flag and word types for the CPU ALU.
package caf_pkg;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_ADC    = 4'd1,
      OP_ADD_SP = 4'd2,
      OP_SUB    = 4'd3,
      OP_SBC    = 4'd4,
      OP_AND    = 4'd5,
      OP_OR     = 4'd6,
      OP_XOR    = 4'd7,
      OP_INC    = 4'd8,
      OP_DEC    = 4'd9,
      OP_CP     = 4'd10
   } op_code_type;

   typedef struct packed {
      logic z;
      logic n;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic        is_wide;
   } req_word_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic        write_enable;
      logic        zero_flag;
      logic        subtract_flag;
      logic        carry_flag;
   } rsp_word_type;

endpackage

@@ rtl/caf_alu.sv @@
// Combinational ALU datapath: result, write enable and next flags for one word.
module caf_alu
   import caf_pkg::*;
(
   input  req_word_type req_word,
   input  flags_type    flags_cur,
   output rsp_word_type rsp_word,
   output flags_type    flags_nxt
);

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic [16:0] sum17;
   logic [8:0]  sum9;
   logic [8:0]  adc9;
   logic [15:0] sp_sum;
   logic [8:0]  diff9;
   logic [8:0]  sub9;
   logic [9:0]  sbc10;
   logic [15:0] inc16;
   logic [15:0] dec16;
   logic [15:0] res;
   logic        we;
   flags_type   fl;

   assign a8     = req_word.operand_a[7:0];
   assign b8     = req_word.operand_b[7:0];
   assign sum17  = {1'b0, req_word.operand_a} + {1'b0, req_word.operand_b};
   assign sum9   = {1'b0, a8} + {1'b0, b8};
   assign adc9   = sum9 + {8'd0, flags_cur.c};
   assign sp_sum = req_word.operand_a + {{8{b8[7]}}, b8};
   assign diff9  = {1'b0, a8} - {1'b0, b8};
   assign sub9   = {1'b0, b8} + {8'd0, flags_cur.c};
   assign sbc10  = {2'b00, a8} - {1'b0, sub9};
   assign inc16  = req_word.operand_a + 16'd1;
   assign dec16  = req_word.operand_a - 16'd1;

   always_comb begin
      res = 16'd0;
      we  = 1'b1;
      fl  = flags_cur;
      case (req_word.op)
         OP_ADD: begin
            fl.n = 1'b0;
            if (req_word.is_wide) begin
               res  = sum17[15:0];
               fl.c = sum17[16];
            end else begin
               res  = {8'd0, sum9[7:0]};
               fl.z = (sum9[7:0] == 8'd0);
               fl.c = sum9[8];
            end
         end
         OP_ADC: begin
            res  = {8'd0, adc9[7:0]};
            fl.z = (adc9[7:0] == 8'd0);
            fl.n = 1'b0;
            fl.c = adc9[8];
         end
         OP_ADD_SP: begin
            res  = sp_sum;
            fl.z = 1'b0;
            fl.n = 1'b0;
            fl.c = sum9[8];
         end
         OP_SUB, OP_CP: begin
            res  = {8'd0, diff9[7:0]};
            fl.z = (diff9[7:0] == 8'd0);
            fl.n = 1'b1;
            fl.c = diff9[8];
            if (req_word.op == OP_CP) begin
               res = 16'd0;
               we  = 1'b0;
            end
         end
         OP_SBC: begin
            res  = {8'd0, sbc10[7:0]};
            fl.z = (sbc10[7:0] == 8'd0);
            fl.n = 1'b1;
            fl.c = sbc10[9];
         end
         OP_AND, OP_OR, OP_XOR: begin
            if (req_word.op == OP_AND) begin
               res = {8'd0, a8 & b8};
            end else if (req_word.op == OP_OR) begin
               res = {8'd0, a8 | b8};
            end else begin
               res = {8'd0, a8 ^ b8};
            end
            fl.z = (res[7:0] == 8'd0);
            fl.n = 1'b0;
            fl.c = 1'b0;
         end
         OP_INC, OP_DEC: begin
            res = (req_word.op == OP_INC) ? inc16 : dec16;
            if (!req_word.is_wide) begin
               res[15:8] = 8'd0;
               fl.z      = (res[7:0] == 8'd0);
               fl.n      = (req_word.op == OP_DEC);
            end
         end
         default: begin
            res = 16'd0;
            we  = 1'b0;
         end
      endcase
   end

   assign flags_nxt              = fl;
   assign rsp_word.result_value  = res;
   assign rsp_word.write_enable  = we;
   assign rsp_word.zero_flag     = fl.z;
   assign rsp_word.subtract_flag = fl.n;
   assign rsp_word.carry_flag    = fl.c;

endmodule

@@ rtl/cpu_alu_with_flags.sv @@
// Top level: 8/16-bit CPU ALU with Z, N, C flags kept across words.
// A request passes the input register, then the result register, before rsp_valid rises.
// One word per cycle when not stalled; the input register can fill while a result waits.
// Flags are updated as each word moves into the result register.
// Reset clears the flags and both valid bits.
module cpu_alu_with_flags
   import caf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_word_ff;
   flags_type    flags_ff;
   flags_type    flags_in;
   rsp_word_type alu_word;
   flags_type    alu_flags;
   logic         out_load;
   logic         in_load;

   caf_alu u_alu (
      .req_word  (in_word_ff),
      .flags_cur (flags_ff),
      .rsp_word  (alu_word),
      .flags_nxt (alu_flags)
   );

   assign out_load     = !out_valid_ff || !rsp_stall;
   assign in_load      = !in_valid_ff || out_load;
   assign req_stall    = !in_load;
   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   assign flags_in     = (out_load && in_valid_ff) ? alu_flags : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_word_ff <= req_word;
      end
      if (out_load && in_valid_ff) begin
         out_word_ff <= alu_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

@@ rtl/caf_checker.sv @@
// Port checker for the CPU ALU, bound to the top level.
module caf_checker
   import caf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("req word changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled while result side free");

   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.write_enable |-> rsp_word.result_value == 16'd0)
      else $error("nonzero result without write enable");

endmodule

bind cpu_alu_with_flags caf_checker u_caf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

@@ test/cpu_alu_with_flags_tb.sv @@
// Self-checking testbench for the CPU ALU: directed rows, random words, flag tracking.
`timescale 1ns / 1ps

module cpu_alu_with_flags_tb;
   import caf_pkg::*;

   localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
   localparam logic [3:0] OP_LAST_CODE    = 4'd15;
   localparam int RANDOM_WORDS = 1600;
   localparam int QUIET_WORDS  = 200;

   typedef struct packed {
      req_word_type word;
      logic         known;
      rsp_word_type expected;
   } alu_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   flags_type    alu_flags = '0;
   rsp_word_type alu_results_due[$];
   int           mismatch_count = 0;
   int           results_checked = 0;
   int           words_sent = 0;
   int           op_hits[16];
   int           stall_left = 0;
   logic         quiet_tail = 1'b0;

   // word fields: op, a, b, wide, known, then result, we, z, n, c
   alu_row_type directed_rows [26] = '{
      {OP_LAST_CODE,    16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
      {OP_ADD,          16'h00FF, 16'h0001, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1},
      {OP_ADC,          16'hAAFF, 16'h55FF, 1'b0, 1'b1, 16'h00FF, 1'b1, 1'b0, 1'b0, 1'b1},
      {OP_ADD,          16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1},
      {OP_AND,          16'h0000, 16'h00FF, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
      {OP_ADD,          16'h1234, 16'h0001, 1'b1, 1'b0, 20'h00000},
      {OP_ADD_SP,       16'hFFF8, 16'h0008, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1},
      {OP_ADD_SP,       16'h0000, 16'h0080, 1'b0, 1'b1, 16'hFF80, 1'b1, 1'b0, 1'b0, 1'b0},
      {OP_ADD_SP,       16'h1234, 16'hFFFF, 1'b1, 1'b0, 20'h00000},
      {OP_SUB,          16'h0000, 16'h0001, 1'b0, 1'b1, 16'h00FF, 1'b1, 1'b0, 1'b1, 1'b1},
      {OP_SUB,          16'h0080, 16'h0080, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
      {OP_SBC,          16'h0000, 16'h00FF, 1'b0, 1'b1, 16'h0001, 1'b1, 1'b0, 1'b1, 1'b1},
      {OP_SBC,          16'h00FF, 16'h00FF, 1'b0, 1'b0, 20'h00000},
      {OP_SBC,          16'h0010, 16'h000F, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
      {OP_OR,           16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
      {OP_XOR,          16'h00FF, 16'h000F, 1'b0, 1'b1, 16'h00F0, 1'b1, 1'b0, 1'b0, 1'b0},
      {OP_AND,          16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h00FF, 1'b1, 1'b0, 1'b0, 1'b0},
      {OP_CP,           16'h0000, 16'h0001, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1},
      {OP_INC,          16'h12FF, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1},
      {OP_DEC,          16'h0000, 16'h0000, 1'b0, 1'b1, 16'h00FF, 1'b1, 1'b0, 1'b1, 1'b1},
      {OP_DEC,          16'h0001, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1},
      {OP_INC,          16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1},
      {OP_DEC,          16'h0000, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1},
      {OP_CP,           16'h005A, 16'h005A, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0},
      {OP_FIRST_UNUSED, 16'h1234, 16'h5678, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0},
      {OP_ADC,          16'h0080, 16'h0080, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1}
   };

   cpu_alu_with_flags i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Updates alu_flags as the block would and returns the result word.
   function automatic rsp_word_type predict_alu(req_word_type w);
      logic [16:0]  sum;
      logic [8:0]   borrow_in;
      logic [7:0]   a8;
      logic [7:0]   b8;
      logic [7:0]   r8;
      logic [15:0]  res;
      logic         we;
      flags_type    f;
      rsp_word_type r;
      a8  = w.operand_a[7:0];
      b8  = w.operand_b[7:0];
      f   = alu_flags;
      res = '0;
      we  = 1'b1;
      case (w.op)
         OP_ADD: begin
            if (w.is_wide) begin
               sum = {1'b0, w.operand_a} + {1'b0, w.operand_b};
               res = sum[15:0];
               f.c = sum[16];
            end else begin
               sum = {9'd0, a8} + {9'd0, b8};
               res = {8'h00, sum[7:0]};
               f.z = (sum[7:0] == 8'h00);
               f.c = sum[8];
            end
            f.n = 1'b0;
         end
         OP_ADC: begin
            sum = {9'd0, a8} + {9'd0, b8} + {16'd0, f.c};
            res = {8'h00, sum[7:0]};
            f.z = (sum[7:0] == 8'h00);
            f.n = 1'b0;
            f.c = sum[8];
         end
         OP_ADD_SP: begin
            sum = {9'd0, a8} + {9'd0, b8};
            res = w.operand_a + {{8{b8[7]}}, b8};
            f.c = sum[8];
            f.z = 1'b0;
            f.n = 1'b0;
         end
         OP_SUB, OP_CP: begin
            r8  = a8 - b8;
            res = {8'h00, r8};
            f.z = (r8 == 8'h00);
            f.n = 1'b1;
            f.c = (a8 < b8);
            if (w.op == OP_CP) begin
               res = '0;
               we  = 1'b0;
            end
         end
         OP_SBC: begin
            borrow_in = {1'b0, b8} + {8'd0, f.c};
            r8  = a8 - borrow_in[7:0];
            res = {8'h00, r8};
            f.z = (r8 == 8'h00);
            f.n = 1'b1;
            f.c = ({1'b0, a8} < borrow_in);
         end
         OP_AND, OP_OR, OP_XOR: begin
            if (w.op == OP_AND) r8 = a8 & b8;
            else if (w.op == OP_OR) r8 = a8 | b8;
            else r8 = a8 ^ b8;
            res = {8'h00, r8};
            f.z = (r8 == 8'h00);
            f.n = 1'b0;
            f.c = 1'b0;
         end
         OP_INC, OP_DEC: begin
            if (w.is_wide) begin
               res = (w.op == OP_INC) ? w.operand_a + 16'd1 : w.operand_a - 16'd1;
            end else begin
               r8  = (w.op == OP_INC) ? a8 + 8'd1 : a8 - 8'd1;
               res = {8'h00, r8};
               f.z = (r8 == 8'h00);
               f.n = (w.op == OP_DEC);
            end
         end
         default: begin
            res = '0;
            we  = 1'b0;
         end
      endcase
      alu_flags       = f;
      r.result_value  = res;
      r.write_enable  = we;
      r.zero_flag     = f.z;
      r.subtract_flag = f.n;
      r.carry_flag    = f.c;
      return r;
   endfunction

   function automatic logic [15:0] pick_operand();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         2: v[7:0] = 8'hFF;
         3: v[7:0] = 8'h00;
         4: v[7:0] = 8'h80;
         default: ;
      endcase
      return v;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      if ($urandom_range(0, 19) == 0)
         w.op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      else
         w.op = 4'($urandom_range(OP_ADD, OP_CP));
      w.operand_a = pick_operand();
      w.operand_b = ($urandom_range(0, 9) == 0) ? w.operand_a : pick_operand();
      w.is_wide   = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      if (mismatch_count < 40)
         $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(req_word_type w, logic known, rsp_word_type typed);
      rsp_word_type predicted;
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted = predict_alu(w);
      alu_results_due.push_back(known ? typed : predicted);
      op_hits[w.op]++;
      words_sent++;
   endtask

   task automatic check_result(rsp_word_type got);
      rsp_word_type want;
      if (alu_results_due.size() == 0) begin
         report_mismatch("result word with nothing pending", got.result_value, 16'h0000);
         return;
      end
      want = alu_results_due.pop_front();
      results_checked++;
      if (got.result_value !== want.result_value)
         report_mismatch("result_value", got.result_value, want.result_value);
      if (got.write_enable !== want.write_enable)
         report_mismatch("write_enable", 16'(got.write_enable), 16'(want.write_enable));
      if (got.zero_flag !== want.zero_flag)
         report_mismatch("zero_flag", 16'(got.zero_flag), 16'(want.zero_flag));
      if (got.subtract_flag !== want.subtract_flag)
         report_mismatch("subtract_flag", 16'(got.subtract_flag), 16'(want.subtract_flag));
      if (got.carry_flag !== want.carry_flag)
         report_mismatch("carry_flag", 16'(got.carry_flag), 16'(want.carry_flag));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_word);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      foreach (op_hits[i]) op_hits[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].expected);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n >= RANDOM_WORDS - QUIET_WORDS) quiet_tail = 1'b1;
         send_word(random_word(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (alu_results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d request words sent (%0d directed), %0d result words checked",
               words_sent, $size(directed_rows), results_checked);
      $display("adc %0d, sbc %0d, add_sp %0d, cp %0d, inc/dec %0d, unused codes %0d",
               op_hits[OP_ADC], op_hits[OP_SBC], op_hits[OP_ADD_SP], op_hits[OP_CP],
               op_hits[OP_INC] + op_hits[OP_DEC],
               words_sent - op_hits[OP_ADD] - op_hits[OP_ADC] - op_hits[OP_ADD_SP]
               - op_hits[OP_SUB] - op_hits[OP_SBC] - op_hits[OP_AND] - op_hits[OP_OR]
               - op_hits[OP_XOR] - op_hits[OP_INC] - op_hits[OP_DEC] - op_hits[OP_CP]);
      if (mismatch_count == 0)
         $display("cpu_alu_with_flags_tb OK");
      else
         $display("cpu_alu_with_flags_tb NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d result words pending", alu_results_due.size());
      $display("cpu_alu_with_flags_tb NOT OK");
      $finish;
   end

endmodule
